// ===== rtl/core/stp_pkg.sv =====
// Shared types and constants for the stepper STEP/DIR pulse generator.
// No dependencies; used by stp_core and stepper_step_dir_pulse_generator.
package stp_pkg;

  localparam int unsigned TIMER_W = 20;
  localparam int unsigned POS_W   = 16;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_MOVE = 2'd1,
    FUNC_HOME = 2'd2
  } func_t;

  localparam logic [1:0] CFG_STEP_PERIOD   = 2'd0;
  localparam logic [1:0] CFG_MOVE_POSITIVE = 2'd1;
  localparam logic [1:0] CFG_MAX_POSITION  = 2'd2;

  typedef struct packed {
    logic [TIMER_W-1:0] step_period_us;
    logic               move_positive;
    logic [POS_W-1:0]   max_position;
  } cfg_t;

  typedef struct packed {
    logic             homed;
    logic             ready_res;
    logic [POS_W-1:0] steps_left;
    logic [POS_W-1:0] position;
    logic             dir_out;
    logic             step_out;
  } result_t;

endpackage

// ===== rtl/core/stp_core.sv =====
// Step/direction sequencer: state registers and their next-value logic.
// Depends on stp_pkg.
module stp_core import stp_pkg::*; #(
  parameter int unsigned STEP_LOW_TICKS  = 100,
  parameter int unsigned HOME_HIGH_TICKS = 500
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [1:0]       func,
  input  logic [POS_W-1:0] step_count,
  input  logic             home_switch,
  input  cfg_t             cfg,
  output result_t          result
);

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_MOVE_LOW   = 3'd1,
    PH_MOVE_HIGH  = 3'd2,
    PH_HOME_CHECK = 3'd3,
    PH_HOME_LOW   = 3'd4,
    PH_HOME_HIGH  = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [TIMER_W-1:0] timer;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   remaining;
    logic               homed;
    logic               ready;
    logic               step_level;
    logic               dir_level;
  } st_t;

  localparam logic [TIMER_W-1:0] LOW_TICKS  = TIMER_W'(STEP_LOW_TICKS);
  localparam logic [TIMER_W-1:0] HOME_TICKS = TIMER_W'(HOME_HIGH_TICKS);

  st_t st, st_next;

  function automatic st_t move_check(input st_t s, input cfg_t c);
    st_t r;
    r = s;
    if (r.remaining == '0 || c.step_period_us == '0) begin
      r.ready = 1'b1;
      r.phase = PH_IDLE;
    end else if ((c.move_positive && r.position >= c.max_position) ||
                 (!c.move_positive && r.position == '0)) begin
      r.remaining = '0;
      r.ready     = 1'b1;
      r.phase     = PH_IDLE;
    end else begin
      r.dir_level  = c.move_positive;
      r.step_level = 1'b0;
      r.timer      = LOW_TICKS;
      r.phase      = PH_MOVE_LOW;
    end
    return r;
  endfunction

  function automatic st_t home_check(input st_t s, input cfg_t c, input logic sw);
    st_t r;
    r = s;
    if (sw) begin
      r.homed      = 1'b1;
      r.step_level = 1'b0;
      r.dir_level  = 1'b1;
      r.position   = '0;
      r.phase      = PH_IDLE;
      if (!r.ready) begin
        r = move_check(r, c);
      end
    end else begin
      r.dir_level  = 1'b0;
      r.step_level = 1'b0;
      r.timer      = LOW_TICKS;
      r.phase      = PH_HOME_LOW;
    end
    return r;
  endfunction

  logic [TIMER_W-1:0] timer_dec;

  assign timer_dec = (st.timer != '0) ? st.timer - 1'b1 : '0;

  always_comb begin
    st_next = st;
    unique case (func)
      FUNC_TICK: begin
        if (st.phase != PH_IDLE) begin
          st_next.timer = timer_dec;
          if (timer_dec == '0) begin
            unique case (st.phase)
              PH_MOVE_LOW: begin
                st_next.step_level = 1'b1;
                if (st.dir_level) begin
                  if (st.position != '1) st_next.position = st.position + 1'b1;
                end else begin
                  if (st.position != '0) st_next.position = st.position - 1'b1;
                end
                if (st.remaining != '0) st_next.remaining = st.remaining - 1'b1;
                st_next.timer = (cfg.step_period_us > LOW_TICKS) ?
                                cfg.step_period_us - LOW_TICKS : '0;
                st_next.phase = PH_MOVE_HIGH;
              end
              PH_MOVE_HIGH:  st_next = move_check(st_next, cfg);
              PH_HOME_CHECK: st_next = home_check(st_next, cfg, home_switch);
              PH_HOME_LOW: begin
                st_next.step_level = 1'b1;
                st_next.timer      = HOME_TICKS;
                st_next.phase      = PH_HOME_HIGH;
              end
              PH_HOME_HIGH:  st_next = home_check(st_next, cfg, home_switch);
              default: begin
                st_next.phase = PH_IDLE;
                st_next.timer = '0;
              end
            endcase
          end
        end
      end
      FUNC_MOVE: begin
        st_next.remaining = step_count;
        st_next.ready     = 1'b0;
        if (st.homed && st.phase == PH_IDLE) begin
          st_next = move_check(st_next, cfg);
        end
      end
      FUNC_HOME: begin
        if (st.phase == PH_IDLE) begin
          if (st.homed) begin
            st_next.step_level = 1'b0;
            st_next.dir_level  = 1'b1;
            st_next.position   = '0;
          end else begin
            st_next.timer = '0;
            st_next.phase = PH_HOME_CHECK;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= PH_IDLE;
      st.timer      <= '0;
      st.position   <= '0;
      st.remaining  <= '0;
      st.homed      <= 1'b0;
      st.ready      <= 1'b1;
      st.step_level <= 1'b0;
      st.dir_level  <= 1'b1;
    end else if (advance) begin
      st <= st_next;
    end
  end

  assign result.step_out   = st_next.step_level;
  assign result.dir_out    = st_next.dir_level;
  assign result.position   = st_next.position;
  assign result.steps_left = st_next.remaining;
  assign result.ready_res  = st_next.ready;
  assign result.homed      = st_next.homed;

  a_idle_timer_clear: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_IDLE |-> st.timer == '0)
    else $error("timer left running in idle");

  a_unhomed_at_zero: assert property (@(posedge clk) disable iff (rst)
    !st.homed |-> st.position == '0)
    else $error("position moved before homing");

  a_move_needs_home: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_MOVE_LOW || st.phase == PH_MOVE_HIGH) |-> st.homed)
    else $error("move running while not homed");

  a_homing_unhomed: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_HOME_CHECK || st.phase == PH_HOME_LOW ||
     st.phase == PH_HOME_HIGH) |-> !st.homed)
    else $error("homing running after home found");

endmodule

// ===== rtl/core/stepper_step_dir_pulse_generator.sv =====
// Stepper STEP/DIR pulse generator top level: request channels, config
// registers and result register. Depends on stp_pkg and stp_core.
//
// Each input request is a one-tick advance (func 0), a move command (func 1,
// step_count steps), a homing command (func 2) or a no-op (func 3); home_switch
// is sampled on ticks. Every accepted request yields exactly one result: the
// STEP and DIR levels, position, steps left, ready and homed flags after
// the request has been applied.
// The result is registered and shows on m_axis in the cycle after acceptance.
// One request is taken per cycle while the receiver keeps up: the state update
// is a single combinational pass from the state registers into the state and
// result registers. When the receiver stalls, the result register holds and
// s_axis_tready drops until it is taken; state advances only on accepted requests.
// Reset: idle, position 0, no steps left, not homed, ready, STEP low, DIR high;
// step_period_us 0, move_positive 0, max_position 65535. The user must write the
// registers via cfg_we/cfg_index/cfg_data only while idle; the block does not check.
module stepper_step_dir_pulse_generator import stp_pkg::*; #(
  parameter int unsigned STEP_LOW_TICKS  = 100,
  parameter int unsigned HOME_HIGH_TICKS = 500
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,  // step_count[15:0], home_switch[16], zero pad
  input  logic [1:0]         s_axis_tuser,  // func[1:0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [39:0]        m_axis_tdata,  // step_out, dir_out, position, steps_left,
                                            // ready_res, homed, zero pad
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [TIMER_W-1:0] cfg_data
);

  cfg_t    cfg;
  result_t result;
  result_t out_reg;
  logic    accept;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_period_us <= '0;
      cfg.move_positive  <= 1'b0;
      cfg.max_position   <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_PERIOD:   cfg.step_period_us <= cfg_data;
        CFG_MOVE_POSITIVE: cfg.move_positive  <= cfg_data[0];
        CFG_MAX_POSITION:  cfg.max_position   <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  stp_core #(
    .STEP_LOW_TICKS  (STEP_LOW_TICKS),
    .HOME_HIGH_TICKS (HOME_HIGH_TICKS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept),
    .func        (s_axis_tuser),
    .step_count  (s_axis_tdata[POS_W-1:0]),
    .home_switch (s_axis_tdata[POS_W]),
    .cfg         (cfg),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= result;
    end
  end

  assign m_axis_tdata = {4'b0, out_reg};

endmodule

// ===== dv/tb.sv =====
// Testbench for stepper_step_dir_pulse_generator: directed table, then random
// move/home/tick/no-op requests, checked by a behavioural predictor or table values.
// Depends on stp_pkg and the RTL top level only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stp_pkg::*;

  localparam logic [1:0]         FUNC_SPARE   = 2'd3;
  localparam logic [TIMER_W-1:0] STEP_LOW     = 20'd100;
  localparam logic [TIMER_W-1:0] HOME_HIGH    = 20'd500;
  localparam int                 RANDOM_ITEMS = 650;
  localparam int                 CYCLE_LIMIT  = 400000;

  typedef enum logic [2:0] {
    PH_IDLE, PH_MOVE_LOW, PH_MOVE_HIGH, PH_HOME_CHECK, PH_HOME_LOW, PH_HOME_HIGH
  } motor_phase_e;

  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  typedef struct packed {
    logic         is_setting;
    logic [1:0]   f;
    logic [15:0]  cnt;
    logic         sw;
    logic [11:0]  reps;
    logic         typed;
    result_t      want;
    logic [19:0]  period;
    logic         upward;
    logic [15:0]  max_pos;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata = '0;   // step_count[15:0], home_switch[16], zero pad
  logic [1:0]         s_axis_tuser = '0;   // func[1:0]
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [39:0]        m_axis_tdata;        // step_out, dir_out, position, steps_left,
                                           // ready_res, homed, zero pad
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [TIMER_W-1:0] cfg_data = '0;

  stepper_step_dir_pulse_generator dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // motor state as predicted
  motor_phase_e       phase_q;
  logic [TIMER_W-1:0] timer_q, period_q;
  logic [POS_W-1:0]   pos_q, left_q, max_q;
  logic               homed_q, ready_q, step_q, dir_q, upward_q;

  result_t pin_reports_due [$];
  int      mismatches = 0;
  int      results_checked = 0;
  int      requests_sent = 0;
  int      steps_made = 0;
  int      settings_loaded = 0;
  int      burst_left = 0;
  int      cycles = 0;

  function automatic result_t pins(logic st, logic dr, logic [15:0] pos, logic [15:0] left,
                                   logic rdy, logic hm);
    result_t r;
    r.step_out = st; r.dir_out = dr; r.position = pos; r.steps_left = left;
    r.ready_res = rdy; r.homed = hm;
    return r;
  endfunction

  function automatic void start_next_step();
    if (left_q == 0 || period_q == 0) begin
      ready_q = 1'b1;
      phase_q = PH_IDLE;
      return;
    end
    if (upward_q ? (pos_q >= max_q) : (pos_q == 0)) begin
      left_q  = '0;
      ready_q = 1'b1;
      phase_q = PH_IDLE;
      return;
    end
    dir_q   = upward_q;
    step_q  = 1'b0;
    timer_q = STEP_LOW;
    phase_q = PH_MOVE_LOW;
  endfunction

  function automatic void sample_home(logic sw);
    if (sw) begin
      homed_q = 1'b1;
      step_q  = 1'b0;
      dir_q   = 1'b1;
      pos_q   = '0;
      phase_q = PH_IDLE;
      if (!ready_q) start_next_step();
    end else begin
      dir_q   = 1'b0;
      step_q  = 1'b0;
      timer_q = STEP_LOW;
      phase_q = PH_HOME_LOW;
    end
  endfunction

  function automatic result_t advance_motor(logic [1:0] f, logic [15:0] cnt, logic sw);
    case (f)
      FUNC_TICK: if (phase_q != PH_IDLE) begin
        if (timer_q != 0) timer_q = timer_q - 1'b1;
        if (timer_q == 0) begin
          case (phase_q)
            PH_MOVE_LOW: begin
              step_q = 1'b1;
              if (dir_q) begin
                if (pos_q != 16'hFFFF) pos_q = pos_q + 1'b1;
              end else if (pos_q != 0) begin
                pos_q = pos_q - 1'b1;
              end
              if (left_q != 0) left_q = left_q - 1'b1;
              timer_q = (period_q > STEP_LOW) ? period_q - STEP_LOW : '0;
              phase_q = PH_MOVE_HIGH;
              steps_made++;
            end
            PH_MOVE_HIGH: start_next_step();
            PH_HOME_CHECK, PH_HOME_HIGH: sample_home(sw);
            PH_HOME_LOW: begin
              step_q  = 1'b1;
              timer_q = HOME_HIGH;
              phase_q = PH_HOME_HIGH;
            end
            default: begin
              phase_q = PH_IDLE;
              timer_q = '0;
            end
          endcase
        end
      end
      FUNC_MOVE: begin
        left_q  = cnt;
        ready_q = 1'b0;
        if (homed_q && phase_q == PH_IDLE) start_next_step();
      end
      FUNC_HOME: if (phase_q == PH_IDLE) begin
        if (homed_q) begin
          step_q = 1'b0;
          dir_q  = 1'b1;
          pos_q  = '0;
        end else begin
          timer_q = '0;
          phase_q = PH_HOME_CHECK;
        end
      end
      default: ;
    endcase
    return pins(step_q, dir_q, pos_q, left_q, ready_q, homed_q);
  endfunction

  function automatic plan_row_t request(logic [1:0] f, logic [15:0] cnt, logic sw,
                                        logic [11:0] reps);
    plan_row_t r;
    r = '0;
    r.f = f; r.cnt = cnt; r.sw = sw; r.reps = reps;
    return r;
  endfunction

  function automatic plan_row_t typed_request(logic [1:0] f, logic [15:0] cnt, logic sw,
                                              result_t want);
    plan_row_t r;
    r = request(f, cnt, sw, 12'd1);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic plan_row_t setting(logic [19:0] period, logic upward,
                                        logic [15:0] max_pos);
    plan_row_t r;
    r = '0;
    r.is_setting = 1'b1; r.period = period; r.upward = upward; r.max_pos = max_pos;
    return r;
  endfunction

  task automatic send_request(logic [1:0] f, logic [15:0] cnt, logic sw, logic typed,
                              result_t want);
    result_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {7'b0, sw, cnt};
    do @(posedge clk); while (!s_axis_tready);
    predicted = advance_motor(f, cnt, sw);
    pin_reports_due.push_back(typed ? want : predicted);
    requests_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
  endtask

  // drop valid and wait until every result is in
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pin_reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(logic [19:0] period, logic upward, logic [15:0] max_pos);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STEP_PERIOD;
    cfg_data  <= period;
    @(posedge clk);
    cfg_index <= CFG_MOVE_POSITIVE;
    cfg_data  <= {19'b0, upward};
    @(posedge clk);
    cfg_index <= CFG_MAX_POSITION;
    cfg_data  <= {4'b0, max_pos};
    @(posedge clk);
    cfg_we <= 1'b0;
    period_q = period;
    upward_q = upward;
    max_q    = max_pos;
    settings_loaded++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // receiver stall pattern
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_run = 0;
  always @(posedge clk) begin
    if (rx_run == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_run  <= $urandom_range(1, 40);
    end else begin
      rx_run <= rx_run - 1;
    end
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:   m_axis_tready <= ~m_axis_tready;
    endcase
  end

  always @(posedge clk) begin : result_check
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[35:0];
      if (pin_reports_due.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want = pin_reports_due.pop_front();
        check_field("step_out", want.step_out, got.step_out);
        check_field("dir_out", want.dir_out, got.dir_out);
        check_field("position", want.position, got.position);
        check_field("steps_left", want.steps_left, got.steps_left);
        check_field("ready_res", want.ready_res, got.ready_res);
        check_field("homed", want.homed, got.homed);
        check_field("pad", 0, m_axis_tdata[39:36]);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding", pin_reports_due.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t   plan [$];
    int          random_items;
    int          phase_len;
    int          pick;
    logic [19:0] period;
    logic [15:0] max_pos;
    logic [15:0] cnt;

    phase_q = PH_IDLE; timer_q = '0; pos_q = '0; left_q = '0;
    homed_q = 1'b0; ready_q = 1'b1; step_q = 1'b0; dir_q = 1'b1;
    period_q = '0; upward_q = 1'b0; max_q = 16'hFFFF;

    plan.push_back(typed_request(FUNC_TICK, 16'h0000, 1'b0, pins(0, 1, 0, 0, 1, 0)));
    plan.push_back(typed_request(FUNC_SPARE, 16'hFFFF, 1'b1, pins(0, 1, 0, 0, 1, 0)));
    // move before homing is held
    plan.push_back(typed_request(FUNC_MOVE, 16'hFFFF, 1'b0, pins(0, 1, 0, 16'hFFFF, 0, 0)));
    plan.push_back(typed_request(FUNC_HOME, 16'h0000, 1'b0, pins(0, 1, 0, 16'hFFFF, 0, 0)));
    plan.push_back(request(FUNC_TICK, 16'h5A5A, 1'b0, 12'd101));
    plan.push_back(request(FUNC_TICK, 16'hA5A5, 1'b1, 12'd500));
    // top limit already reached
    plan.push_back(setting(20'd1000000, 1'b1, 16'd0));
    plan.push_back(typed_request(FUNC_MOVE, 16'd5, 1'b0, pins(0, 1, 0, 0, 1, 1)));
    plan.push_back(setting(20'd150, 1'b1, 16'hFFFF));
    plan.push_back(request(FUNC_MOVE, 16'd3, 1'b0, 12'd1));
    plan.push_back(request(FUNC_TICK, 16'h0000, 1'b0, 12'd100));
    plan.push_back(request(FUNC_MOVE, 16'd2, 1'b1, 12'd1));
    plan.push_back(request(FUNC_HOME, 16'h0000, 1'b1, 12'd1));
    // direction reversed mid-step
    plan.push_back(setting(20'd150, 1'b0, 16'hFFFF));
    plan.push_back(request(FUNC_TICK, 16'h0000, 1'b1, 12'd150));
    plan.push_back(request(FUNC_TICK, 16'hFFFF, 1'b0, 12'd50));
    // period below the low time: zero high time
    plan.push_back(setting(20'd50, 1'b1, 16'hFFFF));
    plan.push_back(request(FUNC_MOVE, 16'd1, 1'b0, 12'd1));
    plan.push_back(request(FUNC_TICK, 16'h0000, 1'b0, 12'd101));
    plan.push_back(request(FUNC_MOVE, 16'd0, 1'b0, 12'd1));
    plan.push_back(setting(20'd0, 1'b1, 16'hFFFF));
    plan.push_back(request(FUNC_MOVE, 16'd4, 1'b0, 12'd1));
    plan.push_back(typed_request(FUNC_HOME, 16'h0000, 1'b0, pins(0, 1, 0, 4, 1, 1)));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_setting) begin
        settle();
        load_settings(plan[i].period, plan[i].upward, plan[i].max_pos);
      end else begin
        repeat (plan[i].reps)
          send_request(plan[i].f, plan[i].cnt, plan[i].sw, plan[i].typed, plan[i].want);
      end
    end

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 7))
        0:       period = '0;
        1:       period = 20'($urandom_range(1, 99));
        2:       period = STEP_LOW;
        6:       period = 20'($urandom_range(1, 600));
        default: period = 20'($urandom_range(101, 180));
      endcase
      case ($urandom_range(0, 4))
        0:       max_pos = '0;
        1:       max_pos = 16'hFFFF;
        2:       max_pos = 16'($urandom);
        default: max_pos = 16'($urandom_range(1, 4));
      endcase
      load_settings(period, 1'($urandom_range(0, 1)), max_pos);
      phase_len = $urandom_range(60, 180);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        cnt  = 16'($urandom);
        if (pick < 8) begin
          if (pick < 6) cnt = 16'($urandom_range(0, 6));
          send_request(FUNC_MOVE, cnt, 1'($urandom_range(0, 1)), 1'b0, '0);
          random_items++;
        end else if (pick < 10) begin
          send_request(FUNC_HOME, cnt, 1'($urandom_range(0, 1)), 1'b0, '0);
          random_items++;
        end else if (pick < 11) begin
          send_request(FUNC_SPARE, cnt, 1'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
          send_request(FUNC_TICK, cnt, 1'($urandom_range(0, 1)), 1'b0, '0);
          random_items++;
        end
      end
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Checked %0d results from %0d requests over %0d register settings.",
             results_checked, requests_sent, settings_loaded);
    $display("Predicted %0d steps, including homing, limits and direction reversal.",
             steps_made);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/stp_pkg.sv
rtl/core/stp_core.sv
rtl/core/stepper_step_dir_pulse_generator.sv
dv/tb.sv
